>>> rtl/core/cron_field_validator_assert.svh
// Assertion macros used by the checker of the schedule validator.
`ifndef CRON_FIELD_VALIDATOR_ASSERT_SVH
`define CRON_FIELD_VALIDATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define CFV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cron_field_validator: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define CFV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cron_field_validator: next-cycle check failed");

`endif

>>> rtl/core/cfv_pkg.sv
// Types, constants and parsing functions of the schedule field validator.
package cfv_pkg;

  localparam int FIELD_COUNT = 5;

  // Number accumulation saturates here, outside every field bound.
  localparam logic [6:0] NUM_SAT = 7'd127;

  // Parser phases of one comma item.
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_STAR  = 3'd1;
  localparam logic [2:0] PH_NUM1  = 3'd2;
  localparam logic [2:0] PH_DASH  = 3'd3;
  localparam logic [2:0] PH_NUM2  = 3'd4;
  localparam logic [2:0] PH_SLASH = 3'd5;
  localparam logic [2:0] PH_STEP  = 3'd6;
  localparam logic [2:0] PH_DEAD  = 3'd7;

  // Field indexes; FLD_NONE marks that no field has failed.
  localparam logic [2:0] FLD_MINUTE  = 3'd0;
  localparam logic [2:0] FLD_HOUR    = 3'd1;
  localparam logic [2:0] FLD_DAY     = 3'd2;
  localparam logic [2:0] FLD_MONTH   = 3'd3;
  localparam logic [2:0] FLD_WEEKDAY = 3'd4;
  localparam logic [2:0] FLD_NONE    = 3'd5;

  // Character codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // One character handed to the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] char_code;
    logic       line_end;
  } cfv_char_t;

  // One line verdict.
  typedef struct packed {
    logic       line_valid;
    logic [2:0] fields_seen;
    logic [2:0] first_bad_field;
  } cfv_result_t;

  // Outcome of feeding one character into an item.
  typedef struct packed {
    logic [2:0] phase;
    logic [6:0] number;
    logic       fail;
  } cfv_feed_t;

  // Bounds check of a finished number against its field.
  function automatic logic number_ok(input logic [2:0] fi, input logic [6:0] nv);
    logic ok;
    case (fi)
      FLD_MINUTE:  ok = (nv <= 7'd59);
      FLD_HOUR:    ok = (nv <= 7'd23);
      FLD_DAY:     ok = (nv <= 7'd31);
      FLD_MONTH:   ok = (nv >= 7'd1) && (nv <= 7'd12);
      FLD_WEEKDAY: ok = (nv <= 7'd6);
      default:     ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Advances the item parser by one non-space character.
  function automatic cfv_feed_t feed_char(input logic [2:0] ph, input logic [6:0] nv,
                                          input logic [2:0] fi, input logic [7:0] c);
    cfv_feed_t  r;
    logic [3:0] d;
    logic [10:0] acc;
    r.phase  = ph;
    r.number = nv;
    r.fail   = 1'b0;
    d   = 4'(c - CH_ZERO);
    acc = {4'b0, nv} * 11'd10 + {7'b0, d};
    if (ph != PH_DEAD) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        case (ph)
          PH_START: begin
            r.phase  = PH_NUM1;
            r.number = {3'b0, d};
          end
          PH_DASH: begin
            r.phase  = PH_NUM2;
            r.number = {3'b0, d};
          end
          PH_SLASH: begin
            r.phase  = PH_STEP;
            r.number = {3'b0, d};
          end
          PH_NUM1, PH_NUM2, PH_STEP: begin
            r.number = (acc > {4'b0, NUM_SAT}) ? NUM_SAT : acc[6:0];
          end
          default: r.fail = 1'b1;
        endcase
      end else if (c == CH_STAR) begin
        if (ph == PH_START) r.phase = PH_STAR;
        else r.fail = 1'b1;
      end else if (c == CH_DASH) begin
        if (ph == PH_NUM1 && number_ok(fi, nv)) r.phase = PH_DASH;
        else r.fail = 1'b1;
      end else if (c == CH_SLASH) begin
        if (ph == PH_STAR) r.phase = PH_SLASH;
        else if (ph == PH_NUM2 && number_ok(fi, nv)) r.phase = PH_SLASH;
        else r.fail = 1'b1;
      end else if (c == CH_COMMA) begin
        if (ph == PH_STAR) r.phase = PH_START;
        else if ((ph == PH_NUM1 || ph == PH_NUM2 || ph == PH_STEP) && number_ok(fi, nv))
          r.phase = PH_START;
        else r.fail = 1'b1;
      end else begin
        r.fail = 1'b1;
      end
    end
    if (r.fail) r.phase = PH_DEAD;
    return r;
  endfunction

  // Tells whether closing a field at this phase makes the field fail.
  function automatic logic close_fails(input logic [2:0] ph, input logic [6:0] nv,
                                       input logic [2:0] fi);
    logic f;
    case (ph)
      PH_NUM1, PH_NUM2, PH_STEP: f = !number_ok(fi, nv);
      PH_STAR, PH_DEAD:          f = 1'b0;
      default:                   f = 1'b1;
    endcase
    return f;
  endfunction

endpackage

>>> rtl/core/cfv_parser.sv
// Parser state registers and the per-character next-state logic.
module cfv_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  cfv_pkg::cfv_char_t   step,
  output logic                 res_valid,
  output cfv_pkg::cfv_result_t res
);

  logic [2:0] field_index, field_index_next;
  logic [2:0] item_phase, item_phase_next;
  logic [6:0] number_value, number_value_next;
  logic       in_gap, in_gap_next;
  logic       error_seen, error_seen_next;
  logic [2:0] error_field, error_field_next;

  // Next state for one character, plus the verdict on the final one.
  always_comb begin
    logic [2:0] fi;
    logic [2:0] ph;
    logic [6:0] nv;
    logic       gap;
    logic       err;
    logic [2:0] ef;
    logic       fail;
    cfv_pkg::cfv_feed_t fr;

    fi   = field_index;
    ph   = item_phase;
    nv   = number_value;
    gap  = in_gap;
    err  = error_seen;
    ef   = error_field;
    fail = 1'b0;
    fr   = '0;

    // Bytes after the fifth field are ignored.
    if (fi < 3'(cfv_pkg::FIELD_COUNT)) begin
      if (step.char_code == cfv_pkg::CH_SPACE) begin
        if (!gap) begin
          fail = cfv_pkg::close_fails(ph, nv, fi);
          if (fail && !err) begin
            err = 1'b1;
            ef  = fi;
          end
          fi  = fi + 3'd1;
          gap = 1'b1;
          ph  = cfv_pkg::PH_START;
          nv  = 7'd0;
        end
      end else begin
        if (gap) begin
          gap = 1'b0;
          ph  = cfv_pkg::PH_START;
          nv  = 7'd0;
        end
        fr = cfv_pkg::feed_char(ph, nv, fi, step.char_code);
        ph = fr.phase;
        nv = fr.number;
        if (fr.fail && !err) begin
          err = 1'b1;
          ef  = fi;
        end
      end
    end

    // The final character closes an open field.
    if (step.line_end && !gap && fi < 3'(cfv_pkg::FIELD_COUNT)) begin
      fail = cfv_pkg::close_fails(ph, nv, fi);
      if (fail && !err) begin
        err = 1'b1;
        ef  = fi;
      end
      fi  = fi + 3'd1;
      gap = 1'b1;
      ph  = cfv_pkg::PH_START;
      nv  = 7'd0;
    end

    res.fields_seen = fi;
    res.line_valid  = !err && (fi >= 3'(cfv_pkg::FIELD_COUNT));
    if (err) res.first_bad_field = ef;
    else if (fi < 3'(cfv_pkg::FIELD_COUNT)) res.first_bad_field = fi;
    else res.first_bad_field = cfv_pkg::FLD_NONE;
    res_valid = step.valid && step.line_end;

    field_index_next  = fi;
    item_phase_next   = ph;
    number_value_next = nv;
    in_gap_next       = gap;
    error_seen_next   = err;
    error_field_next  = ef;

    // A finished line leaves the parser as after reset.
    if (step.line_end) begin
      field_index_next  = 3'd0;
      item_phase_next   = cfv_pkg::PH_START;
      number_value_next = 7'd0;
      in_gap_next       = 1'b1;
      error_seen_next   = 1'b0;
      error_field_next  = cfv_pkg::FLD_NONE;
    end
  end

  // State update on every character that moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      field_index  <= 3'd0;
      item_phase   <= cfv_pkg::PH_START;
      number_value <= 7'd0;
      in_gap       <= 1'b1;
      error_seen   <= 1'b0;
      error_field  <= cfv_pkg::FLD_NONE;
    end else if (step.valid) begin
      field_index  <= field_index_next;
      item_phase   <= item_phase_next;
      number_value <= number_value_next;
      in_gap       <= in_gap_next;
      error_seen   <= error_seen_next;
      error_field  <= error_field_next;
    end
  end

endmodule

>>> rtl/core/cfv_out_reg.sv
// Result register that drives the master-side stream.
module cfv_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  cfv_pkg::cfv_result_t res,
  output logic                 free,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata
);

  cfv_pkg::cfv_result_t held;

  // The register can take a new result when empty or being drained.
  assign free = !m_tvalid || m_tready;

  // Valid flag: set by a load, cleared when the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = {1'b0, held.first_bad_field, held.fields_seen, held.line_valid};

endmodule

>>> rtl/core/cron_field_validator.sv
// Top level of the schedule line field validator.
// Usage:
//   The slave stream carries one byte of a schedule line per transaction;
//   s_tlast marks the final byte. The five fields (minute, hour, day, month,
//   weekday) are checked as the bytes go by, and the final byte yields one
//   verdict transaction on the master stream. Other bytes yield nothing.
//   The final byte passes the input register, and the parser's verdict on it
//   is loaded into the result register, which drives m_tvalid.
//   Throughput: one byte per cycle while no final byte waits for the result
//   register; the parser logic sits between the input and result registers.
//   Stall: while a verdict waits on m_tready, bytes of the next line keep
//   flowing; only its final byte waits in the input register until the
//   result register is free, and s_tready drops for that time.
//   Reset: rst clears the valid flags of both registers and puts the parser
//   at the start of a line, with leading spaces skipped.
module cron_field_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  input  logic       s_tlast,   // line_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] line_valid, [3:1] fields_seen,
                                // [6:4] first_bad_field, [7] zero
);

  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;
  logic       out_free;
  logic       advance;
  logic       res_valid;
  cfv_pkg::cfv_char_t   step;
  cfv_pkg::cfv_result_t res;

  // The held byte moves on unless it is final and the result register is full.
  assign advance  = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  assign step = '{valid: advance, char_code: in_char, line_end: in_last};

  cfv_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .res_valid (res_valid),
    .res       (res)
  );

  cfv_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

>>> rtl/core/cfv_checker.sv
// Port-level checker of the schedule validator and its bind.
`include "cron_field_validator_assert.svh"

module cfv_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  logic       line_ok;
  logic [2:0] seen;
  logic [2:0] bad;
  logic       all_seen;
  logic       none_bad;

  // Verdict fields as packed on the master stream.
  assign line_ok  = m_tdata[0];
  assign seen     = m_tdata[3:1];
  assign bad      = m_tdata[6:4];
  assign all_seen = (seen == 3'(cfv_pkg::FIELD_COUNT));
  assign none_bad = (bad == cfv_pkg::FLD_NONE);

  // A stalled verdict holds.
  `CFV_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // A valid line has all five fields and names no failing field.
  `CFV_ASSERT_NOW(a_valid_line, m_tvalid && line_ok, all_seen && none_bad)

  // An invalid line always names a failing or missing field.
  `CFV_ASSERT_NOW(a_bad_named, m_tvalid && !line_ok, !none_bad && (bad <= seen))

  // Counts stay in range and the pad bit is zero.
  `CFV_ASSERT_NOW(a_range, m_tvalid, (seen <= 3'(cfv_pkg::FIELD_COUNT)) && !m_tdata[7])

endmodule

bind cron_field_validator cfv_checker u_cfv_checker (.*);

>>> bench/cfv_line_checker.sv
// Line checker for the schedule validator: tracks both streams, predicts and compares.
`timescale 1ns / 1ps
module cfv_line_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  input  logic       s_tlast,   // line_end
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [0] line_valid, [3:1] fields_seen,
                                // [6:4] first_bad_field, [7] zero
  output int         mismatch_count,
  output int         verdicts_open,
  output int         verdicts_seen,
  output int         valid_seen
);

  // Parser state of the line being predicted.
  logic [2:0] cur_field;
  logic [2:0] phase;
  logic [6:0] num_acc;
  logic       gap_mode;
  logic       field_failed;
  logic [2:0] fail_field;

  // Verdicts predicted but not yet seen on the master side.
  cfv_pkg::cfv_result_t verdict_q[$];
  cfv_pkg::cfv_result_t want;

  int n_bad = 0;
  int n_seen = 0;
  int n_valid = 0;

  // Bounds of a finished number in the given field.
  function automatic logic fits_field(input logic [2:0] f, input logic [6:0] v);
    case (f)
      cfv_pkg::FLD_MINUTE:  return v <= 7'd59;
      cfv_pkg::FLD_HOUR:    return v <= 7'd23;
      cfv_pkg::FLD_DAY:     return v <= 7'd31;
      cfv_pkg::FLD_MONTH:   return (v >= 7'd1) && (v <= 7'd12);
      cfv_pkg::FLD_WEEKDAY: return v <= 7'd6;
      default:              return 1'b0;
    endcase
  endfunction

  task automatic clear_line();
    cur_field    = cfv_pkg::FLD_MINUTE;
    phase        = cfv_pkg::PH_START;
    num_acc      = 7'd0;
    gap_mode     = 1'b1;
    field_failed = 1'b0;
    fail_field   = cfv_pkg::FLD_NONE;
  endtask

  // Kills the current field; only the first failing field is remembered.
  task automatic kill_item();
    if (phase != cfv_pkg::PH_DEAD) begin
      if (!field_failed) begin
        field_failed = 1'b1;
        fail_field   = cur_field;
      end
      phase = cfv_pkg::PH_DEAD;
    end
  endtask

  task automatic end_number(input logic [2:0] next);
    if (fits_field(cur_field, num_acc)) phase = next;
    else kill_item();
  endtask

  // True while a number is being read.
  function automatic logic in_number(input logic [2:0] ph);
    return ph == cfv_pkg::PH_NUM1 || ph == cfv_pkg::PH_NUM2 || ph == cfv_pkg::PH_STEP;
  endfunction

  // Item grammar for one non-space byte.
  task automatic parse_char(input logic [7:0] c);
    logic [10:0] grown;
    if (phase != cfv_pkg::PH_DEAD) begin
      if (c >= cfv_pkg::CH_ZERO && c <= cfv_pkg::CH_NINE) begin
        case (phase)
          cfv_pkg::PH_START: begin
            phase   = cfv_pkg::PH_NUM1;
            num_acc = {3'd0, c[3:0]};
          end
          cfv_pkg::PH_DASH: begin
            phase   = cfv_pkg::PH_NUM2;
            num_acc = {3'd0, c[3:0]};
          end
          cfv_pkg::PH_SLASH: begin
            phase   = cfv_pkg::PH_STEP;
            num_acc = {3'd0, c[3:0]};
          end
          cfv_pkg::PH_NUM1, cfv_pkg::PH_NUM2, cfv_pkg::PH_STEP: begin
            grown   = {4'd0, num_acc} * 11'd10 + {7'd0, c[3:0]};
            num_acc = (grown > {4'd0, cfv_pkg::NUM_SAT}) ? cfv_pkg::NUM_SAT : grown[6:0];
          end
          default: kill_item();
        endcase
      end else if (c == cfv_pkg::CH_STAR) begin
        if (phase == cfv_pkg::PH_START) phase = cfv_pkg::PH_STAR;
        else kill_item();
      end else if (c == cfv_pkg::CH_DASH) begin
        if (phase == cfv_pkg::PH_NUM1) end_number(cfv_pkg::PH_DASH);
        else kill_item();
      end else if (c == cfv_pkg::CH_SLASH) begin
        if (phase == cfv_pkg::PH_STAR) phase = cfv_pkg::PH_SLASH;
        else if (phase == cfv_pkg::PH_NUM2) end_number(cfv_pkg::PH_SLASH);
        else kill_item();
      end else if (c == cfv_pkg::CH_COMMA) begin
        if (phase == cfv_pkg::PH_STAR) phase = cfv_pkg::PH_START;
        else if (in_number(phase)) end_number(cfv_pkg::PH_START);
        else kill_item();
      end else begin
        kill_item();
      end
    end
  endtask

  // A field ends on a space or at the end of the line.
  task automatic close_field();
    if (in_number(phase)) end_number(cfv_pkg::PH_START);
    else if (phase != cfv_pkg::PH_STAR) kill_item();
    cur_field = cur_field + 3'd1;
    gap_mode  = 1'b1;
    phase     = cfv_pkg::PH_START;
    num_acc   = 7'd0;
  endtask

  // Advances the prediction by one accepted byte; the final byte queues a verdict.
  task automatic take_byte(input logic [7:0] c, input logic last);
    cfv_pkg::cfv_result_t v;
    if (cur_field < 3'(cfv_pkg::FIELD_COUNT)) begin
      if (c == cfv_pkg::CH_SPACE) begin
        if (!gap_mode) close_field();
      end else begin
        if (gap_mode) begin
          gap_mode = 1'b0;
          phase    = cfv_pkg::PH_START;
          num_acc  = 7'd0;
        end
        parse_char(c);
      end
    end
    if (last) begin
      if (!gap_mode && cur_field < 3'(cfv_pkg::FIELD_COUNT)) close_field();
      v.fields_seen = cur_field;
      v.line_valid  = !field_failed && (cur_field >= 3'(cfv_pkg::FIELD_COUNT));
      if (field_failed) v.first_bad_field = fail_field;
      else if (cur_field < 3'(cfv_pkg::FIELD_COUNT)) v.first_bad_field = cur_field;
      else v.first_bad_field = cfv_pkg::FLD_NONE;
      verdict_q.push_back(v);
      clear_line();
    end
  endtask

  task automatic report(input string what, input int exp_val, input int got_val);
    n_bad++;
    if (n_bad <= 10)
      $display("%0t verdict %0d: %s expected %0d, got %0d", $realtime, n_seen, what, exp_val,
               got_val);
  endtask

  // Output side is compared before the input side, so a verdict can never
  // be matched against an expectation queued at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      clear_line();
      verdict_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t unexpected verdict transaction, tdata %02h", $realtime, m_tdata);
        end else begin
          want = verdict_q.pop_front();
          if (m_tdata[0] !== want.line_valid)
            report("line_valid", int'(want.line_valid), int'(m_tdata[0]));
          if (m_tdata[3:1] !== want.fields_seen)
            report("fields_seen", int'(want.fields_seen), int'(m_tdata[3:1]));
          if (m_tdata[6:4] !== want.first_bad_field)
            report("first_bad_field", int'(want.first_bad_field), int'(m_tdata[6:4]));
          if (m_tdata[7] !== 1'b0)
            report("pad bit", 0, int'(m_tdata[7]));
          if (want.line_valid) n_valid++;
          n_seen++;
        end
      end
      if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
    end
    mismatch_count <= n_bad;
    verdicts_open  <= verdict_q.size();
    verdicts_seen  <= n_seen;
    valid_seen     <= n_valid;
  end

endmodule

>>> bench/tb_cron_field_validator.sv
// Testbench top for the schedule validator: drives schedule lines and gives the verdict.
`timescale 1ns / 1ps
module tb_cron_field_validator;

  typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_SLOW} ready_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] char_code
  logic       s_tlast = 1'b0;    // line_end
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [0] line_valid, [3:1] fields_seen,
                                 // [6:4] first_bad_field, [7] zero

  int mismatch_count;
  int verdicts_open;
  int verdicts_seen;
  int valid_seen;

  int burst_left = 0;
  int bytes_sent = 0;
  int lines_sent = 0;
  int directed_lines = 0;
  int hold_left = 0;
  int ready_tick = 0;
  ready_mode_t hold_mode = READY_ALWAYS;

  logic [7:0] line_q[$];
  string sched_chars = "0123456789*,-/ \t";
  int field_min[5] = '{0, 0, 0, 1, 0};
  int field_max[5] = '{59, 23, 31, 12, 6};

  // Broken items dropped into otherwise sound lines.
  string broken[15] = '{",", "1,,2", ",5", "5,", "5/2", "1-*", "1--2", "*//2", "-3", "*1",
                        "**", "3-", "*/", "1-2-3", "*-1"};

  // Hand-written lines: bounds, every item form and each malformed case.
  string directed_text[23] = '{
    "0 0 0 1 0",
    "59 23 31 12 6",
    "60 24 32 13 7",
    "* 24 * * *",
    "* * * 0 *",
    "*/15 1-5/2 1,15,31 1-12 0-6",
    "  * * * * *   extra 99 junk\t",
    "* * *",
    " ",
    "*",
    "1,,2 * * * *",
    ",1 * * * 1,",
    "* * * * 5/2",
    "1-* 1--2 * * *",
    "* *//2 * * *",
    "0000000000000000059 * * * *",
    "* * 99999 * *",
    "*\t* * * *",
    "* * * * 1-",
    "* * * * */",
    "-1 * * * *\r\n",
    "*1 ** * * *",
    "* * * 1-12/0 *"
  };

  cron_field_validator uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  cfv_line_checker line_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatch_count (mismatch_count),
    .verdicts_open  (verdicts_open),
    .verdicts_seen  (verdicts_seen),
    .valid_seen     (valid_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver backpressure: one of four ready patterns, picked again at random.
  always @(posedge clk) begin
    if (hold_left == 0) begin
      hold_mode = ready_mode_t'($urandom_range(0, 3));
      hold_left = $urandom_range(20, 120);
    end
    hold_left--;
    ready_tick++;
    case (hold_mode)
      READY_ALWAYS: m_tready <= 1'b1;
      READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
      READY_SPARSE: m_tready <= (ready_tick % 8 == 0);
      default:      m_tready <= ((ready_tick / 16) % 2 == 0);
    endcase
  end

  // Sends one byte; bursts of random length are separated by random gaps.
  task automatic send_byte(input logic [7:0] c, input logic last);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap = 0;
        burst_left = $urandom_range(20, 60);
      end else begin
        gap = $urandom_range(1, 5);
        burst_left = $urandom_range(1, 8);
      end
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1);
    lines_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    line_q.delete();
    add_text(s);
    send_line();
  endtask

  // A number for field f, in bounds or outside them, sometimes zero-padded.
  task automatic add_number(input int f, input bit legal);
    int v;
    int lo;
    int hi;
    int pick;
    lo = field_min[f];
    hi = field_max[f];
    pick = $urandom_range(0, 9);
    if (legal) v = (pick == 0) ? lo : (pick == 1) ? hi : $urandom_range(lo, hi);
    else if (pick < 4) v = hi + 1;
    else if (pick < 6 && lo > 0) v = lo - 1;
    else if (pick < 8) v = $urandom_range(hi + 1, 127);
    else v = $urandom_range(128, 99999);
    if ($urandom_range(0, 7) == 0) add_text("0");
    add_text($sformatf("%0d", v));
  endtask

  // One item: star, number, range, stepped star or stepped range.
  task automatic add_item(input int f);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      add_text("*");
    end else if (pick < 50) begin
      add_number(f, $urandom_range(0, 24) != 0);
    end else if (pick < 70) begin
      add_number(f, $urandom_range(0, 24) != 0);
      add_text("-");
      add_number(f, $urandom_range(0, 24) != 0);
    end else if (pick < 85) begin
      add_text("*/");
      add_number(f, $urandom_range(0, 24) != 0);
    end else begin
      add_number(f, $urandom_range(0, 24) != 0);
      add_text("-");
      add_number(f, $urandom_range(0, 24) != 0);
      add_text("/");
      add_number(f, $urandom_range(0, 24) != 0);
    end
  endtask

  task automatic add_field(input int f);
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 3) : 1;
    for (int k = 0; k < n; k++) begin
      if (k > 0) add_text(",");
      add_item(f);
    end
  endtask

  function automatic logic [7:0] random_char();
    if ($urandom_range(0, 1) == 0) return sched_chars[$urandom_range(0, sched_chars.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly well-formed lines with random content; the rest carry broken
  // items, random edits or plain noise.
  task automatic make_line();
    int pick;
    int nf;
    int spot;
    int pos;
    int r;
    line_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      nf = 5;
      r = $urandom_range(0, 9);
      if (r == 0) nf = $urandom_range(1, 4);
      else if (r == 1) nf = $urandom_range(6, 7);
      spot = (pick >= 65) ? $urandom_range(0, nf - 1) : -1;
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) line_q.push_back(cfv_pkg::CH_SPACE);
      for (int f = 0; f < nf; f++) begin
        if (f > 0)
          repeat (($urandom_range(0, 5) == 0) ? $urandom_range(2, 3) : 1)
            line_q.push_back(cfv_pkg::CH_SPACE);
        if (f == spot) add_text(broken[$urandom_range(0, 14)]);
        else add_field(f % 5);
      end
      r = $urandom_range(0, 3);
      if (r == 0) begin
        line_q.push_back(cfv_pkg::CH_SPACE);
      end else if (r == 1) begin
        line_q.push_back(cfv_pkg::CH_SPACE);
        repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
      end
      // Random edits: replace, insert or drop a byte.
      if (pick < 65 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          pos = $urandom_range(0, line_q.size() - 1);
          r = $urandom_range(0, 2);
          if (r == 0) line_q[pos] = random_char();
          else if (r == 1) line_q.insert(pos, random_char());
          else if (line_q.size() > 1) line_q.delete(pos);
        end
      end
    end else begin
      repeat ($urandom_range(1, 15)) line_q.push_back(random_char());
    end
    if (line_q.size() == 0) line_q.push_back(cfv_pkg::CH_SPACE);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_text[i]) send_text(directed_text[i]);
    // Bytes with all bits high and all bits low after the fifth field.
    line_q.delete();
    add_text("* * * * * ");
    line_q.push_back(8'hFF);
    line_q.push_back(8'h00);
    send_line();
    directed_lines = lines_sent;

    while (bytes_sent < 1700) begin
      make_line();
      send_line();
    end
    s_tvalid <= 1'b0;

    // Drain the outstanding verdicts, then allow for the pipeline latency.
    do @(posedge clk); while (verdicts_open != 0);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes in %0d schedule lines, %0d of them hand-written.", bytes_sent,
             lines_sent, directed_lines);
    $display("Compared %0d verdicts (%0d valid lines), %0d mismatches.", verdicts_seen,
             valid_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
